FILE: design/mzc_pkg.sv
package mzc_pkg;

	localparam int TIMER_W  = 16;
	localparam int PHASES   = 12;
	localparam int PHASE_W  = 4;
	localparam int TICK_W   = 6;
	localparam int SEC_W    = 8;

	// phase positions of the scheduled actions
	localparam logic [PHASE_W-1:0] PH_ACQ_A   = PHASE_W'(0);
	localparam logic [PHASE_W-1:0] PH_ACQ_B   = PHASE_W'(PHASES / 2);
	localparam logic [PHASE_W-1:0] PH_DRIVE_A = PHASE_W'(PHASES / 4);
	localparam logic [PHASE_W-1:0] PH_DRIVE_B = PHASE_W'((3 * PHASES) / 4);

	localparam logic [TICK_W-1:0] TICKS_50 = TICK_W'(50);
	localparam logic [TICK_W-1:0] TICKS_60 = TICK_W'(60);

	// divide by PHASES: exact reciprocal for any TIMER_W-bit dividend
	localparam int DIV_SHIFT = TIMER_W + $clog2(PHASES);
	localparam int RECIP_W   = TIMER_W + 1;
	localparam int PROD_W    = DIV_SHIFT + TIMER_W;
	localparam longint unsigned RECIP_L =
		((64'd1 << DIV_SHIFT) + 64'(PHASES) - 64'd1) / 64'(PHASES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	localparam logic MODE_CAPTURE = 1'b0;
	localparam logic MODE_COMPARE = 1'b1;

	localparam logic [1:0] MAINS_UNKNOWN = 2'd0;
	localparam logic [1:0] MAINS_50HZ    = 2'd1;
	localparam logic [1:0] MAINS_60HZ    = 2'd2;

	localparam logic [1:0] ACT_NONE    = 2'd0;
	localparam logic [1:0] ACT_ACQUIRE = 2'd1;
	localparam logic [1:0] ACT_DRIVE   = 2'd2;
	localparam logic [1:0] ACT_TICK    = 2'd3;

	typedef struct packed {
		logic               mode;
		logic [TIMER_W-1:0] capture_time;
	} mzc_in_t;

	typedef struct packed {
		logic [TIMER_W-1:0] compare_time;
		logic               compare_load;
		logic [TIMER_W-1:0] period_ticks;
		logic [1:0]         mains_class;
		logic [PHASE_W-1:0] phase_index;
		logic [1:0]         phase_action;
		logic               second_pulse;
		logic               led_level;
		logic               watchdog_level;
		logic [SEC_W-1:0]   seconds_count;
	} mzc_out_t;

endpackage

FILE: design/mzc_step_div.sv
module mzc_step_div (
	input  logic [mzc_pkg::TIMER_W-1:0] period,
	output logic [mzc_pkg::TIMER_W-1:0] step_len
);
	import mzc_pkg::*;

	logic [PROD_W-1:0] prod;

	// floor(period / PHASES) as multiply by rounded-up reciprocal and shift
	assign prod     = PROD_W'(period) * PROD_W'(RECIP);
	assign step_len = prod[DIV_SHIFT +: TIMER_W];

endmodule

FILE: design/mains_zero_cross_phase_scheduler_unit.sv
// Channel  | direction | handshake           | payload
// ---------+-----------+---------------------+---------------------------------
// in       | in        | in_valid / in_stall | in_data  (mzc_in_t: event beat)
// out      | out       | out_valid/out_stall | out_data (mzc_out_t: result beat)
// cfg      | in        | cfg_wr_en           | cfg_wr_data (period threshold)
//
// One result beat per event beat, one beat per cycle sustained while out_stall stays low.
// Stage 1 does period measurement, classing and phase/tick counting; stage 2 does the
// reciprocal multiply for period/12 and the compare add, then lands in the output register.
// Reset (arst_n low) clears all scheduler state and both valid flags.
// A stalled output still lets one beat move into an empty stage 1; in_stall rises only
// when both stages hold beats and the output is stalled.
module mains_zero_cross_phase_scheduler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [mzc_pkg::TIMER_W-1:0]    cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mzc_pkg::mzc_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mzc_pkg::mzc_out_t              out_data
);
	import mzc_pkg::*;

	// ---------------- state owned by stage 1 ----------------
	logic [TIMER_W-1:0] thresh_q;
	logic [TIMER_W-1:0] last_cap_q;
	logic               cap_valid_q;
	logic [TIMER_W-1:0] period_q;
	logic [1:0]         mains_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TICK_W-1:0]  tick_q;
	logic [SEC_W-1:0]   second_q;
	logic               led_q;
	logic               wd_q;

	// ---------------- state owned by stage 2 ----------------
	logic [TIMER_W-1:0] compare_q;
	logic [TIMER_W-1:0] step_q;     // period_q / PHASES, kept in stage 2 order

	// pipeline registers
	logic               s1_valid_q;
	mzc_out_t           res_s1;     // compare fields filled in stage 2
	logic               meas_s1;    // capture that measured a period
	logic               cmpev_s1;   // output-compare event
	logic [TIMER_W-1:0] t_s1;

	logic               out_valid_q;
	mzc_out_t           out_q;

	// handshake
	logic out_ready;
	logic en_s1;
	logic en_s2;

	assign out_ready = !out_valid_q || !out_stall;
	assign in_stall  = s1_valid_q && !out_ready;
	assign en_s1     = in_valid && !in_stall;
	assign en_s2     = s1_valid_q && out_ready;

	// ---------------- stage 1 combinational ----------------
	logic               is_cap;
	logic               meas;
	logic [TIMER_W-1:0] diff;
	logic [TIMER_W-1:0] period_n;
	logic [1:0]         mains_n;
	logic [PHASE_W:0]   phase_inc;
	logic [PHASE_W-1:0] phase_adv;
	logic [PHASE_W-1:0] phase_n;
	logic [1:0]         action_n;
	logic [TICK_W-1:0]  tick_inc;
	logic [TICK_W-1:0]  tick_lim;
	logic [TICK_W-1:0]  tick_n;
	logic               pulse_n;
	logic [SEC_W-1:0]   second_n;
	logic               led_n;

	assign is_cap    = (in_data.mode == MODE_CAPTURE);
	assign meas      = is_cap && cap_valid_q;
	assign diff      = in_data.capture_time - last_cap_q;
	assign phase_inc = {1'b0, phase_q} + (PHASE_W+1)'(1);
	assign phase_adv = (phase_inc >= (PHASE_W+1)'(PHASES)) ? '0 : phase_inc[PHASE_W-1:0];
	assign tick_inc  = tick_q + TICK_W'(1);
	assign tick_lim  = (mains_q == MAINS_50HZ) ? TICKS_50 : TICKS_60;

	always_comb begin
		period_n = period_q;
		mains_n  = mains_q;
		phase_n  = phase_q;
		action_n = ACT_NONE;
		tick_n   = tick_q;
		pulse_n  = 1'b0;
		second_n = second_q;
		led_n    = led_q;
		if (is_cap) begin
			if (cap_valid_q) begin
				period_n = diff;
				mains_n  = (diff > thresh_q) ? MAINS_50HZ : MAINS_60HZ;
				phase_n  = '0;
			end
		end else begin
			phase_n = phase_adv;
			priority if (phase_adv == PH_ACQ_A || phase_adv == PH_ACQ_B) begin
				action_n = ACT_ACQUIRE;
			end else if (phase_adv == PH_DRIVE_A || phase_adv == PH_DRIVE_B) begin
				action_n = ACT_DRIVE;
			end else begin
				// default phases feed the one-second tick
				action_n = ACT_TICK;
				tick_n   = tick_inc;
				if (tick_inc >= tick_lim) begin
					tick_n   = '0;
					pulse_n  = 1'b1;
					second_n = second_q + SEC_W'(1);
					led_n    = !led_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cap_q  <= '0;
			cap_valid_q <= 1'b0;
			period_q    <= '0;
			mains_q     <= MAINS_UNKNOWN;
			phase_q     <= '0;
			tick_q      <= '0;
			second_q    <= '0;
			led_q       <= 1'b0;
			wd_q        <= 1'b0;
		end else if (en_s1) begin
			if (is_cap) begin
				last_cap_q  <= in_data.capture_time;
				cap_valid_q <= 1'b1;
			end
			period_q <= period_n;
			mains_q  <= mains_n;
			phase_q  <= phase_n;
			tick_q   <= tick_n;
			second_q <= second_n;
			led_q    <= led_n;
			wd_q     <= !wd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (en_s1) begin
			s1_valid_q <= 1'b1;
		end else if (en_s2) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			meas_s1               <= meas;
			cmpev_s1              <= !is_cap;
			t_s1                  <= in_data.capture_time;
			res_s1.compare_time   <= '0;
			res_s1.compare_load   <= 1'b0;
			res_s1.period_ticks   <= period_n;
			res_s1.mains_class    <= mains_n;
			res_s1.phase_index    <= phase_n;
			res_s1.phase_action   <= action_n;
			res_s1.second_pulse   <= pulse_n;
			res_s1.led_level      <= led_n;
			res_s1.watchdog_level <= !wd_q;
			res_s1.seconds_count  <= second_n;
		end
	end

	// ---------------- stage 2: compare scheduling ----------------
	logic [TIMER_W-1:0] quot;
	logic [TIMER_W-1:0] compare_n;
	logic               load_n;
	mzc_out_t           res_n;

	mzc_step_div u_div (
		.period   (res_s1.period_ticks),
		.step_len (quot)
	);

	always_comb begin
		compare_n = compare_q;
		load_n    = 1'b0;
		if (meas_s1) begin
			compare_n = t_s1 + quot;
			load_n    = 1'b1;
		end else if (cmpev_s1) begin
			compare_n = compare_q + step_q;
			load_n    = 1'b1;
		end
	end

	// stage 1 fields with the compare fields patched in
	always_comb begin
		res_n              = res_s1;
		res_n.compare_time = compare_n;
		res_n.compare_load = load_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q <= '0;
			step_q    <= '0;
		end else if (en_s2) begin
			compare_q <= compare_n;
			if (meas_s1) begin
				step_q <= quot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			out_q <= res_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && out_valid_q && out_stall))
		else $error("input stalled while pipeline has room");

	a_phase_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.phase_index < PHASE_W'(PHASES)))
		else $error("phase index out of range");

	a_noload_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.compare_load) |->
		(out_data.phase_action == ACT_NONE && !out_data.second_pulse))
		else $error("action reported on an event without compare load");

	a_pulse_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.second_pulse) |-> (out_data.phase_action == ACT_TICK))
		else $error("second pulse outside a tick phase");

	a_tick_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q < TICKS_60)
		else $error("tick counter passed its limit");
`endif

endmodule

FILE: tb/mains_zero_cross_phase_scheduler_unit_tb.sv
`timescale 1ns / 1ps

module mains_zero_cross_phase_scheduler_unit_tb;
	import mzc_pkg::*;

	localparam int DIR_N          = 24;
	localparam int SINK_HOLD      = 80;    // long output hold-off, in cycles
	localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
	localparam int PHASE_BUDGET   = 345;   // random event beats per threshold setting

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [TIMER_W-1:0]  cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	mzc_in_t             in_data;
	logic                out_valid;
	logic                out_stall;
	mzc_out_t            out_data;

	mains_zero_cross_phase_scheduler_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	// Scheduler shadow state; matches the block right after reset.
	logic [TIMER_W-1:0]  thr_setting = '0;
	logic [TIMER_W-1:0]  last_cap    = '0;
	logic                cap_seen    = 1'b0;
	logic [TIMER_W-1:0]  period_now  = '0;
	logic [1:0]          mains_now   = MAINS_UNKNOWN;
	logic [PHASE_W-1:0]  phase_now   = '0;
	logic [TIMER_W-1:0]  compare_now = '0;
	logic [TICK_W-1:0]   tick_now    = '0;
	logic [SEC_W-1:0]    seconds_now = '0;
	logic                led_now     = 1'b0;
	logic                wdog_now    = 1'b0;

	mzc_out_t            predicted_reports[$];
	int unsigned         mismatches  = 0;

	// Traffic shaping shared between the driver, the sink and the phase runner.
	bit                  steady_src  = 1'b0;
	bit                  steady_sink = 1'b0;
	bit                  hold_sink   = 1'b0;
	logic [TIMER_W-1:0]  next_cap    = '0;

	typedef struct packed {
		mzc_in_t  ev;
		logic     typed;   // 1: want is written out by hand below
		mzc_out_t want;
	} stim_row_t;

	// Directed events, programmed with a threshold of 1000 ticks.
	// Hand-written expectations only for the first few beats after reset.
	stim_row_t directed_rows [DIR_N] = '{
		// compare match before any capture: period is 0, compare holds, phase 1 ticks
		'{'{MODE_COMPARE, 16'h0000}, 1'b1,
			'{16'h0000, 1'b0 | 1'b1, 16'h0000, MAINS_UNKNOWN, 4'd1, ACT_TICK,
			1'b0, 1'b0, 1'b1, 8'd0}},
		// first capture only latches the time: no load, and only the watchdog level moves
		'{'{MODE_CAPTURE, 16'h0000}, 1'b1,
			'{16'h0000, 1'b0, 16'h0000, MAINS_UNKNOWN, 4'd1, ACT_NONE,
			1'b0, 1'b0, 1'b0, 8'd0}},
		// largest period: 0xFFFF > 1000 -> 50 Hz, compare wraps to 0xFFFF + 5461
		'{'{MODE_CAPTURE, 16'hFFFF}, 1'b1,
			'{16'h1554, 1'b1, 16'hFFFF, MAINS_50HZ, 4'd0, ACT_NONE,
			1'b0, 1'b0, 1'b1, 8'd0}},
		// a full lap of twelve phases: acquire, drive and tick slots, wrap to 0
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0},
		// timer wrap between captures: period 17
		'{'{MODE_CAPTURE, 16'h0010}, 1'b0, '0},
		// period equal to the threshold classes as 60 Hz
		'{'{MODE_CAPTURE, 16'h03F8}, 1'b0, '0},
		// one above the threshold classes as 50 Hz
		'{'{MODE_CAPTURE, 16'h07E1}, 1'b0, '0},
		// same time twice: period 0, compares then stand still
		'{'{MODE_CAPTURE, 16'h07E1}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h5A5A}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hA5A5}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'hFFFF}, 1'b0, '0},
		// short period: step of one tick
		'{'{MODE_CAPTURE, 16'h07F0}, 1'b0, '0},
		'{'{MODE_COMPARE, 16'h0000}, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advance the shadow scheduler by one event and return the result beat it reports.
	function automatic mzc_out_t schedule_event(input mzc_in_t ev);
		mzc_out_t            r;
		logic [PHASE_W-1:0]  nxt;
		r = '0;
		r.phase_action = ACT_NONE;
		wdog_now = ~wdog_now;
		if (ev.mode == MODE_CAPTURE) begin
			if (cap_seen) begin
				period_now  = ev.capture_time - last_cap;
				mains_now   = (period_now > thr_setting) ? MAINS_50HZ : MAINS_60HZ;
				compare_now = ev.capture_time + TIMER_W'(period_now / PHASES);
				phase_now   = '0;
				r.compare_load = 1'b1;
			end
			last_cap = ev.capture_time;
			cap_seen = 1'b1;
		end else begin
			compare_now = compare_now + TIMER_W'(period_now / PHASES);
			r.compare_load = 1'b1;
			nxt = (int'(phase_now) + 1 >= PHASES) ? '0 : phase_now + 1'b1;
			phase_now = nxt;
			if (nxt == PH_ACQ_A || nxt == PH_ACQ_B) begin
				r.phase_action = ACT_ACQUIRE;
			end else if (nxt == PH_DRIVE_A || nxt == PH_DRIVE_B) begin
				r.phase_action = ACT_DRIVE;
			end else begin
				// unknown class counts like 60 Hz
				r.phase_action = ACT_TICK;
				tick_now = tick_now + 1'b1;
				if (tick_now >= ((mains_now == MAINS_50HZ) ? TICKS_50 : TICKS_60)) begin
					tick_now       = '0;
					seconds_now    = seconds_now + 1'b1;
					led_now        = ~led_now;
					r.second_pulse = 1'b1;
				end
			end
		end
		r.compare_time   = compare_now;
		r.period_ticks   = period_now;
		r.mains_class    = mains_now;
		r.phase_index    = phase_now;
		r.led_level      = led_now;
		r.watchdog_level = wdog_now;
		r.seconds_count  = seconds_now;
		return r;
	endfunction

	// Offer one event beat; called and returning at a falling edge.
	task automatic offer_event(input mzc_in_t ev, input logic use_typed, input mzc_out_t typed_want);
		mzc_out_t predicted;
		while (!steady_src && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= ev;
		do @(posedge clk); while (in_stall);
		predicted = schedule_event(ev);
		predicted_reports.push_back(use_typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// Drop valid and wait for every outstanding result beat.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (predicted_reports.size() != 0);
	endtask

	// Only called with the pipe empty; every event yields a beat, so a short pad is plenty.
	task automatic write_threshold(input logic [TIMER_W-1:0] value);
		repeat (3) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		thr_setting = value;
		@(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
			mismatches++;
		end
	endtask

	// One threshold setting: mostly capture-then-compares laps, some stray events.
	task automatic run_phase(input int phase_id, input logic [TIMER_W-1:0] thr, input int budget);
		int       sent;
		int       burst;
		int       span;
		int       k;
		bit       hold_done;
		bit       pause_done;
		mzc_in_t  ev;
		wait_drained();
		write_threshold(thr);
		// last setting runs with no idling on either side
		steady_src  = (phase_id == 4);
		steady_sink = (phase_id == 4);
		sent = 0;
		hold_done = 1'b0;
		pause_done = 1'b0;
		while (sent < budget) begin
			if ($urandom_range(99) < 75) begin
				case ($urandom_range(2))
					0: span = int'($urandom_range(200));
					1: span = int'(thr) + int'($urandom_range(6)) - 3;  // around the class boundary
					default: span = int'($urandom_range(16'hFFFF));
				endcase
				next_cap = next_cap + TIMER_W'(span);
				ev.mode = MODE_CAPTURE;
				ev.capture_time = next_cap;
				offer_event(ev, 1'b0, '0);
				sent++;
				// usually a clean lap of twelve, sometimes short or overrun
				burst = ($urandom_range(3) == 0) ? int'($urandom_range(24)) : PHASES;
				for (k = 0; k < burst; k++) begin
					ev.mode = MODE_COMPARE;
					ev.capture_time = TIMER_W'($urandom);  // ignored on a compare, still toggled
					offer_event(ev, 1'b0, '0);
					sent++;
				end
			end else begin
				ev.mode = 1'($urandom_range(1));
				ev.capture_time = TIMER_W'($urandom);
				if (ev.mode == MODE_CAPTURE)
					next_cap = ev.capture_time;
				offer_event(ev, 1'b0, '0);
				sent++;
			end
			// sink backs off for a long stretch while events keep coming
			if (phase_id == 2 && !hold_done && sent >= budget / 3) begin
				hold_sink = 1'b1;
				hold_done = 1'b1;
			end
			// source pauses until the pipe is empty
			if (phase_id == 3 && !pause_done && sent >= budget / 2) begin
				wait_drained();
				pause_done = 1'b1;
			end
		end
	endtask

	// Result sink: random stall, a one-shot long hold-off, or none at all.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				out_stall <= 1'b1;
				repeat (SINK_HOLD) @(negedge clk);
				hold_sink = 1'b0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= !steady_sink && ($urandom_range(99) < 21);
			end
		end
	end

	// Result checker: every accepted beat against the oldest prediction.
	initial begin
		mzc_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (predicted_reports.size() == 0) begin
					$error("result beat with no event outstanding: 0x%0h", out_data);
					mismatches++;
				end else begin
					want = predicted_reports.pop_front();
					check_field("compare_time", 32'(want.compare_time),
						32'(out_data.compare_time));
					check_field("compare_load", 32'(want.compare_load),
						32'(out_data.compare_load));
					check_field("period_ticks", 32'(want.period_ticks),
						32'(out_data.period_ticks));
					check_field("mains_class", 32'(want.mains_class),
						32'(out_data.mains_class));
					check_field("phase_index", 32'(want.phase_index),
						32'(out_data.phase_index));
					check_field("phase_action", 32'(want.phase_action),
						32'(out_data.phase_action));
					check_field("second_pulse", 32'(want.second_pulse),
						32'(out_data.second_pulse));
					check_field("led_level", 32'(want.led_level),
						32'(out_data.led_level));
					check_field("watchdog_level", 32'(want.watchdog_level),
						32'(out_data.watchdog_level));
					check_field("seconds_count", 32'(want.seconds_count),
						32'(out_data.seconds_count));
				end
			end
		end
	end

	// Hang detector: too long with no beat on either channel.
	initial begin
		int unsigned stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("mains_zero_cross_phase_scheduler_unit verification failed");
		$finish;
	end

	initial begin
		int r;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_threshold(16'd1000);
		for (r = 0; r < DIR_N; r++)
			offer_event(directed_rows[r].ev, directed_rows[r].typed, directed_rows[r].want);
		next_cap = 16'h07F0;

		// threshold extremes first, then a random, a mid-range and a low setting
		run_phase(0, 16'h0000, PHASE_BUDGET);
		run_phase(1, 16'hFFFF, PHASE_BUDGET);
		run_phase(2, TIMER_W'($urandom), PHASE_BUDGET);
		run_phase(3, 16'd3000, PHASE_BUDGET);
		run_phase(4, TIMER_W'($urandom_range(200)), PHASE_BUDGET);

		wait_drained();
		// two-stage pipe: a few more edges catch any stray beat
		repeat (6) @(posedge clk);
		if (mismatches == 0)
			$display("mains_zero_cross_phase_scheduler_unit verification clean");
		else
			$display("mains_zero_cross_phase_scheduler_unit verification failed");
		$finish;
	end

endmodule
